>>> hw/rtl/tsc_pkg.sv
// Shared widths, fixed-point constants and register indexes for the Taylor sine/cosine unit.
// Used by tsc_mul, tsc_div and taylor_sine_cosine_unit; depends on nothing else.
package tsc_pkg;

    localparam int ANGLE_W   = 25;
    localparam int THR_W     = 31;
    localparam int Q30_W     = 32;
    localparam int MAG_W     = 57;
    localparam int ACC_W     = 2 * MAG_W;
    localparam int FRAC_W    = 48;
    localparam int HALF_W    = 32;
    localparam int DVD_W     = 64;
    localparam int DIV_STEPS = 8;
    localparam int ANG_DVS_W = 12;
    localparam int THR_SHIFT = 18;
    localparam int Q30_SHIFT = 18;

    localparam logic [MAG_W-1:0] PI_Q36  = 57'h0_0000_3243_F6A8_88;
    localparam logic [MAG_W-1:0] QMAG    = {MAG_W{1'b1}};
    localparam logic [MAG_W-1:0] ONE_Q48 = MAG_W'(1) << FRAC_W;
    localparam logic [Q30_W-1:0] Q30_ONE = Q30_W'(1) << 30;

    // Degrees to radians in one rounding step: (a*pi + 90 + 8*180) / (180*16).
    localparam logic [DVD_W-1:0]     ANG_BIAS    = DVD_W'(1530);
    localparam logic [ANG_DVS_W-1:0] ANG_DIVISOR = ANG_DVS_W'(2880);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1074);

    localparam logic REG_STOP_THR  = 1'b0;
    localparam logic REG_EQUAL_THR = 1'b1;

endpackage

>>> hw/rtl/taylor_sine_cosine_unit.sv
// Top level of the Taylor sine/cosine unit: sequencer, series state, registers and output stage.
// Instantiates tsc_mul and tsc_div; uses tsc_pkg.
//
// Usage: each request on the s_ channel carries an angle in degrees (unsigned Q9.16).
// One response on the m_ channel follows with sine and cosine (signed Q2.30) in m_tdata
// and the nearly-equal flag in m_tuser. Two registers are written through cfg_wr_en,
// cfg_addr and cfg_wr_data: index 0 is the series stop threshold, index 1 the equality
// threshold, both unsigned Q1.30; they take effect for the next request if written while idle,
// which the block does not enforce. The block handles one request at a time and s_tready
// is low while it works. Each request uses the shared multiplier and the divider for the
// angle conversion, the multiplier again for x squared, and both once more for every
// added series term; at most MAX_TERMS - 1 terms are added to each series.
// The finished result sits in an output register, so a new request is accepted while
// the previous response is still waiting; when the receiver stalls, the next result
// waits in the sequencer until the output register is free.
// Reset (aresetn low, synchronous) returns to idle, drops m_tvalid and sets both
// thresholds to 1074.
module taylor_sine_cosine_unit #(
    parameter int MAX_TERMS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [24:0] angle_degrees
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [31:0] sine_value, [63:32] cosine_value
    output logic        m_tuser,     // [0] nearly_equal
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [30:0] cfg_wr_data
);
    import tsc_pkg::*;

    localparam int N_W    = $clog2(2 * MAX_TERMS);
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int D_MAX  = (2 * MAX_TERMS - 2) * (2 * MAX_TERMS - 1);
    localparam int DVS_W  = ($clog2(D_MAX + 1) > ANG_DVS_W) ? $clog2(D_MAX + 1) : ANG_DVS_W;
    localparam int Q30M_W = MAG_W - Q30_SHIFT + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANG_MUL,
        ST_ANG_DIV,
        ST_X2_MUL,
        ST_TERM_CHECK,
        ST_TERM_MUL,
        ST_TERM_DIV,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [THR_W-1:0]         stop_thr_reg;
    logic [THR_W-1:0]         equal_thr_reg;
    logic                     mul_start_reg;
    logic [MAG_W-1:0]         mul_a_reg;
    logic [MAG_W-1:0]         mul_b_reg;
    logic                     div_start_reg;
    logic [DVD_W-1:0]         div_dvd_reg;
    logic [DVS_W-1:0]         div_dvs_reg;
    logic [MAG_W-1:0]         x_reg;
    logic [MAG_W-1:0]         x2_reg;
    logic [MAG_W-1:0]         t_reg;
    logic signed [MAG_W:0]    sum_reg;
    logic                     neg_reg;
    logic [N_W-1:0]           n_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     cos_pass_reg;
    logic signed [Q30_W-1:0]  sin_reg;
    logic signed [Q30_W-1:0]  cos_reg;
    logic                     m_tvalid_reg;
    logic [63:0]              m_tdata_reg;
    logic                     m_tuser_reg;

    logic                     mul_done;
    logic [ACC_W-1:0]         mul_product;
    logic [MAG_W-1:0]         mul_rounded;
    logic                     div_done;
    logic [DVD_W-1:0]         div_quotient;

    logic [N_W-1:0]           np1, np2;
    logic [2*N_W-1:0]         d_prod;
    logic [DVS_W-1:0]         d_val;
    logic [MAG_W-1:0]         thr_q48;
    logic                     more_terms;
    logic [MAG_W-1:0]         t_new;
    logic signed [MAG_W+1:0]  sum_wide;
    logic signed [MAG_W+1:0]  qmag_wide;
    logic signed [MAG_W:0]    sum_next;
    logic signed [Q30_W-1:0]  sum_q30;
    logic signed [Q30_W:0]    diff;
    logic [Q30_W:0]           diff_mag;
    logic                     near_next;
    logic                     out_free;

    function automatic logic signed [Q30_W-1:0] to_q30(input logic signed [MAG_W:0] v);
        logic [MAG_W:0]      mag;
        logic [MAG_W:0]      rsum;
        logic [Q30M_W-1:0]   m;
        logic [Q30_W-1:0]    c;
        mag  = v[MAG_W] ? $unsigned(-v) : $unsigned(v);
        rsum = mag + ((MAG_W+1)'(1) << (Q30_SHIFT - 1));
        m    = rsum[MAG_W:Q30_SHIFT];
        if (m > Q30M_W'(Q30_ONE)) begin
            c = Q30_ONE;
        end else begin
            c = m[Q30_W-1:0];
        end
        return v[MAG_W] ? -$signed(c) : $signed(c);
    endfunction

    tsc_mul u_tsc_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .product (mul_product),
        .rounded (mul_rounded)
    );

    tsc_div #(
        .DVS_W (DVS_W)
    ) u_tsc_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dvs_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        np1        = n_reg + N_W'(1);
        np2        = n_reg + N_W'(2);
        d_prod     = (2*N_W)'(np1) * (2*N_W)'(np2);
        d_val      = DVS_W'(d_prod);
        thr_q48    = MAG_W'(stop_thr_reg) << THR_SHIFT;
        more_terms = (count_reg < CNT_W'(MAX_TERMS)) && (t_reg >= thr_q48);
        t_new      = div_quotient[MAG_W-1:0];
        qmag_wide  = $signed({2'b00, QMAG});
        if (!neg_reg) begin
            sum_wide = $signed({sum_reg[MAG_W], sum_reg}) - $signed({2'b00, t_new});
        end else begin
            sum_wide = $signed({sum_reg[MAG_W], sum_reg}) + $signed({2'b00, t_new});
        end
        if (sum_wide > qmag_wide) begin
            sum_next = $signed({1'b0, QMAG});
        end else if (sum_wide < -qmag_wide) begin
            sum_next = -$signed({1'b0, QMAG});
        end else begin
            sum_next = sum_wide[MAG_W:0];
        end
        sum_q30   = to_q30(sum_reg);
        diff      = $signed({sin_reg[Q30_W-1], sin_reg}) - $signed({cos_reg[Q30_W-1], cos_reg});
        diff_mag  = diff[Q30_W] ? $unsigned(-diff) : $unsigned(diff);
        near_next = diff_mag <= (Q30_W+1)'(equal_thr_reg);
        out_free  = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_thr_reg  <= THR_RESET;
            equal_thr_reg <= THR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_STOP_THR:  stop_thr_reg  <= cfg_wr_data;
                REG_EQUAL_THR: equal_thr_reg <= cfg_wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mul_a_reg     <= MAG_W'(s_tdata[ANGLE_W-1:0]);
                        mul_b_reg     <= PI_Q36;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_ANG_MUL;
                    end
                end
                ST_ANG_MUL: begin
                    if (mul_done) begin
                        div_dvd_reg   <= mul_product[DVD_W-1:0] + ANG_BIAS;
                        div_dvs_reg   <= DVS_W'(ANG_DIVISOR);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_ANG_DIV;
                    end
                end
                ST_ANG_DIV: begin
                    if (div_done) begin
                        x_reg         <= div_quotient[MAG_W-1:0];
                        mul_a_reg     <= div_quotient[MAG_W-1:0];
                        mul_b_reg     <= div_quotient[MAG_W-1:0];
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_X2_MUL;
                    end
                end
                ST_X2_MUL: begin
                    if (mul_done) begin
                        x2_reg       <= mul_rounded;
                        t_reg        <= x_reg;
                        sum_reg      <= $signed({1'b0, x_reg});
                        neg_reg      <= 1'b0;
                        n_reg        <= N_W'(1);
                        count_reg    <= CNT_W'(1);
                        cos_pass_reg <= 1'b0;
                        state_reg    <= ST_TERM_CHECK;
                    end
                end
                ST_TERM_CHECK: begin
                    if (more_terms) begin
                        mul_a_reg     <= t_reg;
                        mul_b_reg     <= x2_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_TERM_MUL;
                    end else if (!cos_pass_reg) begin
                        sin_reg      <= sum_q30;
                        t_reg        <= ONE_Q48;
                        sum_reg      <= $signed({1'b0, ONE_Q48});
                        neg_reg      <= 1'b0;
                        n_reg        <= '0;
                        count_reg    <= CNT_W'(1);
                        cos_pass_reg <= 1'b1;
                    end else begin
                        cos_reg   <= sum_q30;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_TERM_MUL: begin
                    if (mul_done) begin
                        div_dvd_reg   <= DVD_W'(mul_rounded) + DVD_W'(d_val >> 1);
                        div_dvs_reg   <= d_val;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_TERM_DIV;
                    end
                end
                ST_TERM_DIV: begin
                    if (div_done) begin
                        t_reg     <= t_new;
                        sum_reg   <= sum_next;
                        neg_reg   <= !neg_reg;
                        n_reg     <= n_reg + N_W'(2);
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= ST_TERM_CHECK;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tdata_reg  <= {cos_reg, sin_reg};
                        m_tuser_reg  <= near_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> hw/rtl/tsc_mul.sv
// Shared 57 x 57 bit magnitude multiplier built from one 32 x 32 multiplier used for four partial products.
// Gives the full product and the Q48 result rounded half up and saturated; uses tsc_pkg.
module tsc_mul (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tsc_pkg::MAG_W-1:0]  op_a,
    input  logic [tsc_pkg::MAG_W-1:0]  op_b,
    output logic                       done,
    output logic [tsc_pkg::ACC_W-1:0]  product,
    output logic [tsc_pkg::MAG_W-1:0]  rounded
);
    import tsc_pkg::*;

    localparam int PP_CNT = 4;
    localparam int CNT_W  = 3;
    localparam int PP_W   = 2 * HALF_W;
    localparam int RND_W  = ACC_W - FRAC_W + 1;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MAG_W-1:0]  a_reg;
    logic [MAG_W-1:0]  b_reg;
    logic [PP_W-1:0]   pp_reg;
    logic [1:0]        pp_idx_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [MAG_W-1:0]  res_reg;

    logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
    logic [HALF_W-1:0] mul_x, mul_y;
    logic [PP_W-1:0]   pp_next;
    logic [ACC_W-1:0]  pp_shifted;
    logic [ACC_W:0]    rnd_sum;
    logic [RND_W-1:0]  rnd_hi;
    logic [MAG_W-1:0]  sat_next;

    always_comb begin
        a_lo = a_reg[HALF_W-1:0];
        b_lo = b_reg[HALF_W-1:0];
        a_hi = {{(2*HALF_W-MAG_W){1'b0}}, a_reg[MAG_W-1:HALF_W]};
        b_hi = {{(2*HALF_W-MAG_W){1'b0}}, b_reg[MAG_W-1:HALF_W]};
        unique case (cnt_reg[1:0])
            2'd0: begin mul_x = a_lo; mul_y = b_lo; end
            2'd1: begin mul_x = a_lo; mul_y = b_hi; end
            2'd2: begin mul_x = a_hi; mul_y = b_lo; end
            2'd3: begin mul_x = a_hi; mul_y = b_hi; end
        endcase
        pp_next = mul_x * mul_y;
        unique case (pp_idx_reg)
            2'd0:       pp_shifted = ACC_W'(pp_reg);
            2'd1, 2'd2: pp_shifted = ACC_W'(pp_reg) << HALF_W;
            2'd3:       pp_shifted = ACC_W'(pp_reg) << (2 * HALF_W);
        endcase
        rnd_sum = {1'b0, acc_reg} + ((ACC_W+1)'(1) << (FRAC_W - 1));
        rnd_hi  = rnd_sum[ACC_W:FRAC_W];
        if (|rnd_hi[RND_W-1:MAG_W]) begin
            sat_next = QMAG;
        end else begin
            sat_next = rnd_hi[MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= op_a;
                b_reg    <= op_b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (cnt_reg < CNT_W'(PP_CNT)) begin
                    pp_reg     <= pp_next;
                    pp_idx_reg <= cnt_reg[1:0];
                end
                if (cnt_reg != '0 && cnt_reg <= CNT_W'(PP_CNT)) begin
                    acc_reg <= acc_reg + pp_shifted;
                end
                if (cnt_reg == CNT_W'(PP_CNT + 1)) begin
                    res_reg  <= sat_next;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
    assign rounded = res_reg;

endmodule

>>> hw/rtl/tsc_div.sv
// Iterative restoring divider for a 64-bit dividend by a narrow divisor, eight quotient bits a cycle.
// Serves both the degree conversion and the per-term scaling; uses tsc_pkg.
module tsc_div #(
    parameter int DVS_W = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tsc_pkg::DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]           divisor,
    output logic                       done,
    output logic [tsc_pkg::DVD_W-1:0]  quotient
);
    import tsc_pkg::*;

    localparam int CYCLES = DVD_W / DIV_STEPS;
    localparam int CNT_W  = $clog2(CYCLES);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_reg;

    logic [DVS_W-1:0]     rem_next;
    logic [DIV_STEPS-1:0] qbits;
    logic [DVS_W:0]       trial;

    always_comb begin
        rem_next = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {rem_next, dvd_reg[DVD_W-1-i]};
            if (trial >= {1'b0, dvs_reg}) begin
                trial                  = trial - {1'b0, dvs_reg};
                qbits[DIV_STEPS-1-i]   = 1'b1;
            end
            rem_next = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dvd_reg <= dvd_reg << DIV_STEPS;
                quo_reg <= {quo_reg[DVD_W-DIV_STEPS-1:0], qbits};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/tsc_checker.sv
// Port-level checks for the Taylor sine/cosine unit and the bind that attaches them.
// Sees only the top-level ports of taylor_sine_cosine_unit.
module tsc_port_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("Block not idle after reset.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Request accepted while the previous one is still in work.");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled response changed or was dropped.");

    a_sine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824) &&
                     ($signed(m_tdata[31:0]) >= -32'sd1073741824))
        else $error("Sine outside the clamped Q2.30 range.");

    a_equal_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[31:0] == m_tdata[63:32]) |-> m_tuser)
        else $error("Equal sine and cosine not flagged as nearly equal.");

endmodule

bind taylor_sine_cosine_unit tsc_port_assertions u_tsc_checker (.*);
